>>> sv/hrs_pkg.sv
package hrs_pkg;

  localparam int WIN    = 12;
  localparam int FILL_W = 4;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [2:0] KIND_URI_BYTE  = 3'd0;
  localparam logic [2:0] KIND_URI_END   = 3'd1;
  localparam logic [2:0] KIND_HOST_BYTE = 3'd2;
  localparam logic [2:0] KIND_HOST_END  = 3'd3;
  localparam logic [2:0] KIND_SUMMARY   = 3'd4;

  localparam logic [1:0] VER_UNKNOWN = 2'd0;
  localparam logic [1:0] VER_1_0     = 2'd1;
  localparam logic [1:0] VER_1_1     = 2'd2;

  localparam logic [1:0] CONN_UNKNOWN    = 2'd0;
  localparam logic [1:0] CONN_KEEP_ALIVE = 2'd1;
  localparam logic [1:0] CONN_CLOSE      = 2'd2;

  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SP    = 8'd32;
  localparam logic [7:0] CH_SLASH = 8'd47;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_ONE   = 8'd49;
  localparam logic [7:0] CH_C     = 8'd67;
  localparam logic [7:0] CH_E_UP  = 8'd69;
  localparam logic [7:0] CH_G     = 8'd71;
  localparam logic [7:0] CH_H     = 8'd72;
  localparam logic [7:0] CH_P     = 8'd80;
  localparam logic [7:0] CH_T     = 8'd84;
  localparam logic [7:0] CH_E     = 8'd101;
  localparam logic [7:0] CH_O     = 8'd111;

  localparam logic [4:0][7:0] HOST_TAG = {8'd58, 8'd116, 8'd115, 8'd111, 8'd72};
  localparam logic [10:0][7:0] CONN_TAG =
    {8'd58, 8'd110, 8'd111, 8'd105, 8'd116, 8'd99, 8'd101, 8'd110, 8'd110, 8'd111, 8'd67};

  // One scan position: the byte under scan at win[0], lookahead behind it.
  typedef struct packed {
    logic [WIN-1:0][7:0] win;
    logic [FILL_W-1:0]   avail;
    logic                summary;
  } hrs_job_t;

endpackage

>>> sv/http_request_header_scanner.sv
// Channel  | Handshake            | Payload
// ---------+----------------------+----------------------------------------------
// input    | in_valid / in_ready  | req_byte, end_of_request
// output   | out_valid / out_ready| kind, text_byte, version, conn_mode,
//          |                      | uri_complete, host_complete, malformed, run_end
//
// A byte is taken each cycle the request streams and the queue has room; each
// byte past the first eleven yields one scan job, at most one result per cycle.
// On the last byte the front drains its 12-byte window, one position a cycle
// while the queue has room, then issues the summary; input is held meanwhile.
// The job queue lets the front keep taking bytes while a result waits.
// Reset is synchronous and active high; it clears window fill, queue and scan
// state. Output stalls back up through the queue into in_ready.
module http_request_header_scanner
  import hrs_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] req_byte,
  input  logic       end_of_request,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] kind,
  output logic [7:0] text_byte,
  output logic [1:0] version,
  output logic [1:0] conn_mode,
  output logic       uri_complete,
  output logic       host_complete,
  output logic       malformed,
  output logic       run_end
);

  // Front to queue: scan jobs, each the window seen from one position.
  logic     push;
  hrs_job_t push_job;
  logic     q_ready;
  // Queue to back.
  logic     job_valid;
  hrs_job_t job;
  logic     pop;

  // Hold bytes in the lookahead window and cut out scan jobs.
  hrs_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .req_byte       (req_byte),
    .end_of_request (end_of_request),
    .push           (push),
    .push_job       (push_job),
    .q_ready        (q_ready)
  );

  // Decouple the window from the scanner so each side stalls on its own.
  hrs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .q_ready   (q_ready),
    .pop_valid (job_valid),
    .pop_job   (job),
    .pop       (pop)
  );

  // Run the header state machine and register each result.
  hrs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .job_valid     (job_valid),
    .job           (job),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .text_byte     (text_byte),
    .version       (version),
    .conn_mode     (conn_mode),
    .uri_complete  (uri_complete),
    .host_complete (host_complete),
    .malformed     (malformed),
    .run_end       (run_end)
  );

endmodule

>>> sv/hrs_front.sv
module hrs_front
  import hrs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] req_byte,
  input  logic       end_of_request,
  output logic       push,
  output hrs_job_t   push_job,
  input  logic       q_ready
);

  logic [WIN-1:0][7:0] win;
  logic [FILL_W-1:0]   fill;
  logic                draining;
  logic                accept;
  logic                full_step;

  assign in_ready  = !draining && q_ready;
  assign accept    = in_valid && in_ready;
  assign full_step = accept && !end_of_request && (fill == FILL_W'(WIN - 1));

  always_comb begin
    push     = 1'b0;
    push_job = '0;
    if (draining && q_ready) begin
      push = 1'b1;
      if (fill == '0) begin
        push_job.summary = 1'b1;
      end else begin
        push_job.win   = win;
        push_job.avail = fill;
      end
    end else if (full_step) begin
      push           = 1'b1;
      push_job.win   = win;
      push_job.win[WIN-1] = req_byte;
      push_job.avail = FILL_W'(WIN);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (full_step) begin
        for (int i = 0; i < WIN - 2; i++) win[i] <= win[i+1];
        win[WIN-2] <= req_byte;
      end else begin
        win[fill] <= req_byte;
      end
    end
    if (draining && q_ready && fill != '0) begin
      for (int i = 0; i < WIN - 1; i++) win[i] <= win[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      draining <= 1'b0;
    end else if (accept) begin
      if (end_of_request) begin
        fill     <= fill + 1'b1;
        draining <= 1'b1;
      end else if (!full_step) begin
        fill <= fill + 1'b1;
      end
    end else if (draining && q_ready) begin
      if (fill == '0) draining <= 1'b0;
      else fill <= fill - 1'b1;
    end
  end

endmodule

>>> sv/hrs_queue.sv
module hrs_queue
  import hrs_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  hrs_job_t push_job,
  output logic     q_ready,
  output logic     pop_valid,
  output hrs_job_t pop_job,
  input  logic     pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  hrs_job_t        mem [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign q_ready   = (count != CW'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_job   = mem[rd_ptr];
  assign do_push   = push && q_ready;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

>>> sv/hrs_back.sv
module hrs_back
  import hrs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       job_valid,
  input  hrs_job_t   job,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] kind,
  output logic [7:0] text_byte,
  output logic [1:0] version,
  output logic [1:0] conn_mode,
  output logic       uri_complete,
  output logic       host_complete,
  output logic       malformed,
  output logic       run_end
);

  localparam logic [3:0] ST_START     = 4'd0;
  localparam logic [3:0] ST_GET       = 4'd1;
  localparam logic [3:0] ST_URI       = 4'd2;
  localparam logic [3:0] ST_URI_END   = 4'd3;
  localparam logic [3:0] ST_CRLF      = 4'd4;
  localparam logic [3:0] ST_HOST      = 4'd5;
  localparam logic [3:0] ST_HOST_TEXT = 4'd6;
  localparam logic [3:0] ST_CONN      = 4'd7;
  localparam logic [3:0] ST_OTHER     = 4'd8;

  logic [3:0] state, state_next;
  logic [3:0] skip, skip_next;
  logic [1:0] ver, ver_next;
  logic       f_uri, f_uri_next;
  logic       f_host, f_host_next;
  logic       f_bad, f_bad_next;
  logic       emit;
  logic [2:0] emit_kind;
  logic [7:0] emit_byte;
  logic [7:0] c;
  logic       host_hit;
  logic       conn_hit;
  logic       lf_next;

  assign pop = job_valid && (!out_valid || out_ready);
  assign c   = job.win[0];
  assign lf_next = (job.avail > FILL_W'(1)) && (job.win[1] == CH_LF);

  always_comb begin
    host_hit = (job.avail > FILL_W'(6));
    for (int k = 0; k < 5; k++) if (job.win[k] != HOST_TAG[k]) host_hit = 1'b0;
    conn_hit = (job.avail > FILL_W'(11));
    for (int k = 0; k < 11; k++) if (job.win[k] != CONN_TAG[k]) conn_hit = 1'b0;
  end

  always_comb begin
    state_next  = state;
    skip_next   = skip;
    ver_next    = ver;
    f_uri_next  = f_uri;
    f_host_next = f_host;
    f_bad_next  = f_bad;
    emit        = 1'b0;
    emit_kind   = KIND_URI_BYTE;
    emit_byte   = '0;
    if (job.summary) begin
      emit        = 1'b1;
      emit_kind   = KIND_SUMMARY;
      state_next  = ST_START;
      skip_next   = '0;
      ver_next    = VER_UNKNOWN;
      f_uri_next  = 1'b0;
      f_host_next = 1'b0;
      f_bad_next  = 1'b0;
    end else if (skip != '0) begin
      skip_next = skip - 1'b1;
    end else begin
      case (state)
        ST_START: begin
          if (c == CH_G && job.avail > FILL_W'(4) && job.win[1] == CH_E_UP &&
              job.win[2] == CH_T && job.win[3] == CH_SP) begin
            skip_next  = 4'd3;
            state_next = ST_GET;
          end
        end
        ST_GET: begin
          if (c != CH_SP) begin
            state_next = ST_URI;
            emit       = 1'b1;
            emit_byte  = c;
          end
        end
        ST_URI: begin
          emit = 1'b1;
          if (c == CH_SP) begin
            state_next = ST_URI_END;
            f_uri_next = 1'b1;
            emit_kind  = KIND_URI_END;
          end else begin
            emit_byte = c;
          end
        end
        ST_URI_END: begin
          if (c == CH_H && job.avail > FILL_W'(8) && job.win[1] == CH_T &&
              job.win[2] == CH_T && job.win[3] == CH_P && job.win[4] == CH_SLASH) begin
            if (job.win[5] == CH_ONE && job.win[7] == CH_ONE) ver_next = VER_1_1;
            else if (job.win[5] == CH_ONE && job.win[7] == CH_ZERO) ver_next = VER_1_0;
            skip_next  = 4'd7;
            state_next = ST_OTHER;
          end
        end
        ST_CRLF: begin
          if (c == CH_H && host_hit) begin
            skip_next  = 4'd5;
            state_next = ST_HOST;
          end else if (c == CH_C && conn_hit) begin
            skip_next  = 4'd10;
            state_next = ST_CONN;
          end else if (c != CH_CR) begin
            state_next = ST_OTHER;
          end else if (lf_next) begin
            skip_next  = 4'd1;
            state_next = ST_OTHER;
          end else begin
            f_bad_next = 1'b1;
          end
        end
        ST_HOST: begin
          if (c != CH_SP) begin
            state_next = ST_HOST_TEXT;
            emit       = !lf_next;
            emit_kind  = KIND_HOST_BYTE;
            emit_byte  = c;
          end
        end
        ST_HOST_TEXT: begin
          emit = 1'b1;
          if (c == CH_LF) begin
            state_next  = ST_OTHER;
            f_host_next = 1'b1;
            emit_kind   = KIND_HOST_END;
          end else begin
            emit      = !lf_next;
            emit_kind = KIND_HOST_BYTE;
            emit_byte = c;
          end
        end
        ST_CONN: begin
          if (c == CH_E || c == CH_O) state_next = ST_OTHER;
        end
        default: begin
          if (c == CH_CR && job.avail > FILL_W'(2) && job.win[1] == CH_LF) begin
            skip_next  = 4'd1;
            state_next = ST_CRLF;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_START;
      skip      <= '0;
      ver       <= VER_UNKNOWN;
      f_uri     <= 1'b0;
      f_host    <= 1'b0;
      f_bad     <= 1'b0;
      out_valid <= 1'b0;
    end else if (pop) begin
      state     <= state_next;
      skip      <= skip_next;
      ver       <= ver_next;
      f_uri     <= f_uri_next;
      f_host    <= f_host_next;
      f_bad     <= f_bad_next;
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload: summary fields stay zero except on the summary.
  always_ff @(posedge clk) begin
    if (pop && emit) begin
      kind          <= emit_kind;
      text_byte     <= emit_byte;
      version       <= job.summary ? ver : VER_UNKNOWN;
      conn_mode     <= !job.summary       ? CONN_UNKNOWN :
                       (ver == VER_1_1)   ? CONN_KEEP_ALIVE :
                       (ver == VER_1_0)   ? CONN_CLOSE : CONN_UNKNOWN;
      uri_complete  <= job.summary && f_uri;
      host_complete <= job.summary && f_host;
      malformed     <= job.summary && f_bad;
      run_end       <= job.summary;
    end
  end

endmodule

>>> sv/hrs_checker.sv
module hrs_checker
  import hrs_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] kind,
  input logic [7:0] text_byte,
  input logic [1:0] version,
  input logic [1:0] conn_mode,
  input logic       uri_complete,
  input logic       host_complete,
  input logic       malformed,
  input logic       run_end
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(text_byte) &&
      $stable(run_end))
    else $error("stalled result changed");

  a_run_end_summary: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (run_end == (kind == KIND_SUMMARY)))
    else $error("run_end does not match summary kind");

  a_text_only_bytes: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_URI_BYTE && kind != KIND_HOST_BYTE |-> text_byte == 8'd0)
    else $error("text byte set on a non-byte result");

  a_summary_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_SUMMARY |->
      version == VER_UNKNOWN && conn_mode == CONN_UNKNOWN && !uri_complete &&
      !host_complete && !malformed)
    else $error("summary field set on a text result");

  a_conn_from_version: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_SUMMARY |->
      (version == VER_1_1 && conn_mode == CONN_KEEP_ALIVE) ||
      (version == VER_1_0 && conn_mode == CONN_CLOSE) ||
      (version == VER_UNKNOWN && conn_mode == CONN_UNKNOWN))
    else $error("connection mode does not follow version");

endmodule

bind http_request_header_scanner hrs_checker u_hrs_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .kind          (kind),
  .text_byte     (text_byte),
  .version       (version),
  .conn_mode     (conn_mode),
  .uri_complete  (uri_complete),
  .host_complete (host_complete),
  .malformed     (malformed),
  .run_end       (run_end)
);
